// ===== sv/gaps_pkg.sv =====
// Shared types, constants and helpers of the grid path search unit.
// Used by the channel interfaces and by every module of the block.
package gaps_pkg;

  localparam int GRID_MAX = 32;
  localparam int COORD_W  = 5;
  localparam int IDX_W    = 2 * COORD_W;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int COST_W   = 14;
  localparam int STAMP_W  = 13;
  localparam int LEN_W    = 11;
  localparam int SIZE_W   = 6;
  localparam int F_W      = COST_W + 1;
  localparam int DATA_W   = COST_W + 2 + STAMP_W;

  localparam logic [COST_W-1:0] STEP_COST = COST_W'(10);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(CELLS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(CELLS);
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(32);

  // Input kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_FOUND  = 3'd1;
  localparam logic [2:0] ST_NOPATH = 3'd2;
  localparam logic [2:0] ST_CELL   = 3'd3;
  localparam logic [2:0] ST_END    = 3'd4;

  // Step directions.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_GRID_SIZE = 3'd0;
  localparam logic [2:0] REG_START_X   = 3'd1;
  localparam logic [2:0] REG_START_Y   = 3'd2;
  localparam logic [2:0] REG_GOAL_X    = 3'd3;
  localparam logic [2:0] REG_GOAL_Y    = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               wall;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  grid_size;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDLE,
    OP_WALL_CLR,
    OP_MARK_CLR,
    OP_GOAL,
    OP_CLOSE,
    OP_NB_RD,
    OP_NB_WR,
    OP_SCAN,
    OP_PICK,
    OP_LEN_RD,
    OP_LEN_STEP,
    OP_FOUND,
    OP_WALK_RD,
    OP_WALK_STEP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic nb_ok;
    logic dir_last;
    logic at_goal;
    logic len_done;
    logic have_best;
    logic is_search;
    logic step_walk;
    logic out_free;
  } status_t;

  // One step from c in direction d, wrapping at the coordinate width.
  function automatic coord_t gaps_move(input logic [1:0] d, input coord_t c);
    coord_t r;
    r = c;
    case (d)
      DIR_UP:    r.y = c.y - COORD_W'(1);
      DIR_RIGHT: r.x = c.x + COORD_W'(1);
      DIR_DOWN:  r.y = c.y + COORD_W'(1);
      default:   r.x = c.x - COORD_W'(1);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/gaps_in_if.sv =====
// Input channel of the grid path search unit: valid, ready and one item.
// Depends on gaps_pkg for the item type.
interface gaps_in_if import gaps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/gaps_out_if.sv =====
// Result channel of the grid path search unit: valid, ready and one item.
// Depends on gaps_pkg for the item type.
interface gaps_out_if import gaps_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/gaps_regs.sv =====
// APB-style configuration registers: grid size, start and goal cells.
// Depends on gaps_pkg.
module gaps_regs import gaps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size <= SIZE_W'(29);
      cfg.start_x   <= COORD_W'(1);
      cfg.start_y   <= COORD_W'(1);
      cfg.goal_x    <= COORD_W'(27);
      cfg.goal_y    <= COORD_W'(27);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GRID_SIZE: cfg.grid_size <= pwdata[SIZE_W-1:0];
        REG_START_X:   cfg.start_x   <= pwdata[COORD_W-1:0];
        REG_START_Y:   cfg.start_y   <= pwdata[COORD_W-1:0];
        REG_GOAL_X:    cfg.goal_x    <= pwdata[COORD_W-1:0];
        REG_GOAL_Y:    cfg.goal_y    <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_SIZE: prdata = {{(32-SIZE_W){1'b0}}, cfg.grid_size};
      REG_START_X:   prdata = {{(32-COORD_W){1'b0}}, cfg.start_x};
      REG_START_Y:   prdata = {{(32-COORD_W){1'b0}}, cfg.start_y};
      REG_GOAL_X:    prdata = {{(32-COORD_W){1'b0}}, cfg.goal_x};
      REG_GOAL_Y:    prdata = {{(32-COORD_W){1'b0}}, cfg.goal_y};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/gaps_ctrl.sv =====
// Controller state machine of the grid path search unit.
// Depends on gaps_pkg; drives commands to gaps_dp and reads its status.
module gaps_ctrl import gaps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_WINIT, S_IDLE, S_CLR, S_GOAL, S_CLOSE, S_NRD, S_NWR, S_SCAN,
    S_DR1, S_DR2, S_PICK, S_LEN, S_LENW, S_FOUND, S_WALK, S_WALKW
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd.accept = accept;
    cmd.op     = OP_NONE;
    unique case (state)
      S_WINIT: begin
        cmd.op = OP_WALL_CLR;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (accept && st.is_search) state_next = S_CLR;
        else if (accept && st.step_walk) state_next = S_WALK;
      end
      S_CLR: begin
        cmd.op = OP_MARK_CLR;
        if (st.sweep_last) state_next = S_GOAL;
      end
      S_GOAL: begin
        cmd.op     = OP_GOAL;
        state_next = st.at_goal ? S_LEN : S_CLOSE;
      end
      S_CLOSE: begin
        cmd.op     = OP_CLOSE;
        state_next = S_NRD;
      end
      S_NRD: begin
        cmd.op = OP_NB_RD;
        if (st.nb_ok) state_next = S_NWR;
        else if (st.dir_last) state_next = S_SCAN;
      end
      S_NWR: begin
        cmd.op     = OP_NB_WR;
        state_next = st.dir_last ? S_SCAN : S_NRD;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (st.sweep_last) state_next = S_DR1;
      end
      S_DR1: state_next = S_DR2;
      S_DR2: state_next = S_PICK;
      S_PICK: begin
        cmd.op     = OP_PICK;
        state_next = st.have_best ? S_GOAL : S_IDLE;
      end
      S_LEN: begin
        cmd.op     = OP_LEN_RD;
        state_next = st.len_done ? S_FOUND : S_LENW;
      end
      S_LENW: begin
        cmd.op     = OP_LEN_STEP;
        state_next = S_LEN;
      end
      S_FOUND: begin
        cmd.op     = OP_FOUND;
        state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.op     = OP_WALK_RD;
        state_next = S_WALKW;
      end
      S_WALKW: begin
        cmd.op     = OP_WALK_STEP;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WINIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/gaps_dp.sv =====
// Datapath of the grid path search unit: cell memories, open-set scan,
// neighbor update, path walk and the result register. Depends on gaps_pkg.
module gaps_dp import gaps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output status_t   st,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // Cell memories. Mark bit 1 is closed, bit 0 is open.
  logic              wall_mem [CELLS];
  logic [1:0]        mark_mem [CELLS];
  logic [DATA_W-1:0] data_mem [CELLS];

  logic              wall_q;
  logic [1:0]        mark_q;
  logic [DATA_W-1:0] data_q;

  logic [IDX_W-1:0]   cnt;
  logic [1:0]         dir;
  coord_t             cur;
  logic [COST_W-1:0]  g_cur;
  logic [STAMP_W-1:0] stamp;
  logic [IDX_W-1:0]   nb_addr;
  coord_t             ln;
  logic [LEN_W-1:0]   ln_len;
  coord_t             walk;
  logic               walk_active;
  logic [LEN_W-1:0]   hop;

  logic               s1_v;
  logic [IDX_W-1:0]   s1_idx;
  logic               s2_v;
  logic [F_W-1:0]     s2_f;
  logic [COST_W-1:0]  s2_g;
  logic [STAMP_W-1:0] s2_s;
  logic [IDX_W-1:0]   s2_idx;
  logic               have;
  logic [IDX_W-1:0]   best_idx;
  logic [F_W-1:0]     best_f;
  logic [COST_W-1:0]  best_g;
  logic [STAMP_W-1:0] best_s;

  logic [SIZE_W-1:0]  lim;
  logic               nb_ok;
  coord_t             nb_c;
  logic [COST_W-1:0]  cost_new;
  logic [COST_W-1:0]  dq_cost;
  logic [1:0]         dq_par;
  logic               nb_take;
  logic [IDX_W-1:0]   rd_addr;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [SIZE_W-1:0]  dsum;
  logic [F_W-1:0]     h;
  logic               better;
  logic               rd_cell;
  logic               load_out;
  out_item_t          out_next;
  coord_t             sx;

  assign sx.x     = cfg.start_x;
  assign sx.y     = cfg.start_y;
  assign lim      = (cfg.grid_size > SIZE_MAX) ? SIZE_MAX : cfg.grid_size;
  assign nb_c     = gaps_move(dir, cur);
  assign cost_new = g_cur + STEP_COST;
  assign dq_cost  = data_q[DATA_W-1 -: COST_W];
  assign dq_par   = data_q[STAMP_W +: 2];
  assign nb_take  = !mark_q[1] && !wall_q && (!mark_q[0] || (cost_new < dq_cost));
  assign rd_cell  = walk_active && (hop != '0);

  always_comb begin
    case (dir)
      DIR_UP:    nb_ok = cur.y > COORD_W'(1);
      DIR_RIGHT: nb_ok = ({1'b0, cur.x} + SIZE_W'(1)) < lim;
      DIR_DOWN:  nb_ok = ({1'b0, cur.y} + SIZE_W'(1)) < lim;
      default:   nb_ok = cur.x > COORD_W'(1);
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_NB_RD:   rd_addr = {nb_c.y, nb_c.x};
      OP_LEN_RD:  rd_addr = {ln.y, ln.x};
      OP_WALK_RD: rd_addr = {walk.y, walk.x};
      default:    rd_addr = cnt;
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    wall_q <= wall_mem[rd_addr];
    mark_q <= mark_mem[rd_addr];
    data_q <= data_mem[rd_addr];
    if (cmd.op == OP_WALL_CLR) begin
      wall_mem[cnt] <= 1'b0;
    end else if (cmd.accept && in_item.kind == KIND_LOAD) begin
      wall_mem[{in_item.cell_y, in_item.cell_x}] <= in_item.wall;
    end
    if (cmd.op == OP_MARK_CLR) begin
      mark_mem[cnt] <= 2'b00;
    end else if (cmd.op == OP_CLOSE) begin
      mark_mem[{cur.y, cur.x}] <= 2'b10;
    end else if (cmd.op == OP_NB_WR && nb_take) begin
      mark_mem[nb_addr] <= 2'b01;
    end
    if (cmd.op == OP_NB_WR && nb_take) begin
      data_mem[nb_addr] <= {cost_new, dir + 2'd2, stamp};
    end
  end

  // Scan pipeline: memory read, score, compare.
  assign dx   = (s1_idx[COORD_W-1:0] > cfg.goal_x) ? s1_idx[COORD_W-1:0] - cfg.goal_x
                                                   : cfg.goal_x - s1_idx[COORD_W-1:0];
  assign dy   = (s1_idx[IDX_W-1:COORD_W] > cfg.goal_y) ? s1_idx[IDX_W-1:COORD_W] - cfg.goal_y
                                                       : cfg.goal_y - s1_idx[IDX_W-1:COORD_W];
  assign dsum = {1'b0, dx} + {1'b0, dy};
  assign h    = F_W'({dsum, 3'b000}) + F_W'({dsum, 1'b0});

  assign better = !have || (s2_f < best_f) ||
                  ((s2_f == best_f) && ((s2_g < best_g) ||
                                        ((s2_g == best_g) && (s2_s < best_s))));

  always_ff @(posedge clk) begin
    s1_idx <= rd_addr;
    s2_f   <= F_W'(dq_cost) + h;
    s2_g   <= dq_cost;
    s2_s   <= data_q[STAMP_W-1:0];
    s2_idx <= s1_idx;
    if (s2_v && better) begin
      best_idx <= s2_idx;
      best_f   <= s2_f;
      best_g   <= s2_g;
      best_s   <= s2_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      have <= 1'b0;
    end else begin
      s1_v <= (cmd.op == OP_SCAN);
      s2_v <= s1_v && mark_q[0];
      if (cmd.op == OP_SCAN && cnt == '0) have <= 1'b0;
      else if (s2_v && better) have <= 1'b1;
    end
  end

  // Search and walk control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      dir         <= DIR_UP;
      walk_active <= 1'b0;
      hop         <= '0;
    end else begin
      if (cmd.op == OP_WALL_CLR || cmd.op == OP_MARK_CLR || cmd.op == OP_SCAN) begin
        cnt <= cnt + IDX_W'(1);
      end
      case (cmd.op)
        OP_IDLE: begin
          if (cmd.accept && in_item.kind == KIND_SEARCH) begin
            cur   <= sx;
            g_cur <= '0;
            stamp <= '0;
          end else if (cmd.accept && in_item.kind == KIND_READ) begin
            if (rd_cell) begin
              hop <= hop - LEN_W'(1);
              if (hop == LEN_W'(1)) walk_active <= 1'b0;
            end else begin
              walk_active <= 1'b0;
            end
          end
        end
        OP_GOAL: begin
          ln     <= cur;
          ln_len <= LEN_W'(1);
          dir    <= DIR_UP;
        end
        OP_NB_RD: begin
          nb_addr <= {nb_c.y, nb_c.x};
          if (!nb_ok) dir <= dir + 2'd1;
        end
        OP_NB_WR: begin
          dir <= dir + 2'd1;
          if (nb_take) stamp <= stamp + STAMP_W'(1);
        end
        OP_PICK: begin
          if (have) begin
            cur   <= {best_idx[COORD_W-1:0], best_idx[IDX_W-1:COORD_W]};
            g_cur <= best_g;
          end else begin
            walk_active <= 1'b0;
            hop         <= '0;
          end
        end
        OP_LEN_STEP: begin
          ln     <= gaps_move(dq_par, ln);
          ln_len <= ln_len + LEN_W'(1);
        end
        OP_FOUND: begin
          walk.x      <= cfg.goal_x;
          walk.y      <= cfg.goal_y;
          walk_active <= 1'b1;
          hop         <= ln_len;
        end
        OP_WALK_STEP: walk <= gaps_move(dq_par, walk);
        default: ;
      endcase
    end
  end

  // Result register.
  always_comb begin
    out_next = '0;
    load_out = 1'b0;
    if (cmd.accept) begin
      load_out = 1'b1;
      if (in_item.kind == KIND_READ) begin
        if (rd_cell) begin
          out_next.status = ST_CELL;
          out_next.out_x  = walk.x;
          out_next.out_y  = walk.y;
          out_next.last   = (hop == LEN_W'(1));
        end else begin
          out_next.status = ST_END;
        end
      end else begin
        load_out = (in_item.kind != KIND_SEARCH);
        out_next.status = ST_LOAD;
      end
    end else if (cmd.op == OP_PICK && !have) begin
      load_out        = 1'b1;
      out_next.status = ST_NOPATH;
    end else if (cmd.op == OP_FOUND) begin
      load_out             = 1'b1;
      out_next.status      = ST_FOUND;
      out_next.path_length = ln_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_item <= out_next;
  end

  assign st.sweep_last = (cnt == IDX_LAST);
  assign st.nb_ok      = nb_ok;
  assign st.dir_last   = (dir == DIR_LEFT);
  assign st.at_goal    = (cur.x == cfg.goal_x) && (cur.y == cfg.goal_y);
  assign st.len_done   = ((ln.x == cfg.start_x) && (ln.y == cfg.start_y)) ||
                         (ln_len == LEN_MAX);
  assign st.have_best  = have;
  assign st.is_search  = (in_item.kind == KIND_SEARCH);
  assign st.step_walk  = (in_item.kind == KIND_READ) && walk_active && (hop > LEN_W'(1));
  assign st.out_free   = !out_valid || out_ready;

endmodule

// ===== sv/grid_astar_path_search_unit.sv =====
// Grid A* path search unit. Loads and reads return one result the cycle after
// acceptance; a read that moves the walk on holds the input through S_WALK and S_WALKW.
// A search clears the marks, then per expanded cell closes it, updates its neighbours
// and scans the open set, then steps back along the parents to count the path cells.
// After reset a pass over every cell clears the wall map; no item is accepted then.
module grid_astar_path_search_unit import gaps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gaps_in_if.sink     in_ch,
  gaps_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  gaps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gaps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gaps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_item   (in_ch.payload),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for grid_astar_path_search_unit: wall loads, searches and path reads.
// It predicts every result with its own A* search and compares each result field by field.
// Depends on gaps_pkg, gaps_in_if, gaps_out_if and the unit itself.
`timescale 1ns / 100ps

module testbench;
  import gaps_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 300000;
  localparam int unsigned ITEM_GOAL = 850;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gaps_in_if  in_ch();
  gaps_out_if out_ch();

  grid_astar_path_search_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the configuration registers.
  logic [5:0] cfg_size;
  logic [4:0] cfg_sx, cfg_sy, cfg_gx, cfg_gy;

  // Predicted state of the unit.
  bit          wall_m   [CELLS];
  bit          open_m   [CELLS];
  bit          closed_m [CELLS];
  logic [13:0] cost_m   [CELLS];
  logic [1:0]  par_m    [CELLS];
  logic [12:0] stamp_m  [CELLS];
  logic [12:0] stamp_ctr;
  logic [4:0]  walk_x, walk_y;
  bit          walk_on;
  logic [10:0] hops_left;

  in_item_t  feed_q [$];
  out_item_t route_q [$];
  bit          feed_taken;
  int unsigned feed_gap, stall_left, idle_cycles, errors, items_made;
  bit          calm;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One step on the 32 by 32 store, wrapping at the coordinate width; c is {y, x}.
  function automatic logic [9:0] hop(input logic [1:0] d, input logic [9:0] c);
    logic [4:0] x, y;
    x = c[4:0];
    y = c[9:5];
    case (d)
      DIR_UP:    y = y - 5'd1;
      DIR_RIGHT: x = x + 5'd1;
      DIR_DOWN:  y = y + 5'd1;
      default:   x = x - 5'd1;
    endcase
    return {y, x};
  endfunction

  // Runs A* on the mirrored state; returns the path length, or 0 for no path.
  function automatic logic [10:0] search_len();
    int unsigned lim, iter, d, i, g, nc, f, bf, bg, bs, dx, dy, len;
    logic [9:0]  cur, nb, best, at;
    logic [4:0]  cx, cy;
    bit          have, ok;
    lim = (cfg_size > 32) ? 32 : cfg_size;
    foreach (open_m[k]) begin
      open_m[k] = 0;
      closed_m[k] = 0;
    end
    stamp_ctr = 0;
    cx = cfg_sx;
    cy = cfg_sy;
    cost_m[{cy, cx}] = 0;
    for (iter = 0; iter <= CELLS; iter++) begin
      cur = {cy, cx};
      if (cx == cfg_gx && cy == cfg_gy) begin
        at = cur;
        len = 1;
        while (at != {cfg_sy, cfg_sx} && len < CELLS) begin
          at = hop(par_m[at], at);
          len++;
        end
        return len;
      end
      closed_m[cur] = 1;
      g = cost_m[cur];
      for (d = 0; d < 4; d++) begin
        case (d)
          0: ok = cy > 1;
          1: ok = int'(cx) + 1 < lim;
          2: ok = int'(cy) + 1 < lim;
          default: ok = cx > 1;
        endcase
        if (ok) begin
          nb = hop(d[1:0], cur);
          if (!closed_m[nb] && !wall_m[nb]) begin
            nc = (g + 10) & 32'h3fff;
            if (!open_m[nb] || nc < cost_m[nb]) begin
              cost_m[nb] = nc[13:0];
              par_m[nb] = d[1:0] + 2'd2;
              open_m[nb] = 1;
              stamp_m[nb] = stamp_ctr;
              stamp_ctr = stamp_ctr + 13'd1;
            end
          end
        end
      end
      have = 0;
      best = 0;
      bf = 0;
      bg = 0;
      bs = 0;
      for (i = 0; i < CELLS; i++) begin
        if (open_m[i]) begin
          dx = (i % 32 > cfg_gx) ? i % 32 - cfg_gx : cfg_gx - i % 32;
          dy = (i / 32 > cfg_gy) ? i / 32 - cfg_gy : cfg_gy - i / 32;
          g = cost_m[i];
          f = g + 10 * (dx + dy);
          if (!have || f < bf || (f == bf && (g < bg || (g == bg && stamp_m[i] < bs)))) begin
            have = 1;
            best = i[9:0];
            bf = f;
            bg = g;
            bs = stamp_m[i];
          end
        end
      end
      if (!have) return 0;
      open_m[best] = 0;
      cx = best[4:0];
      cy = best[9:5];
    end
    return 0;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    logic [10:0] len;
    r = '0;
    r.status = ST_LOAD;
    case (it.kind)
      KIND_LOAD: wall_m[{it.cell_y, it.cell_x}] = it.wall;
      KIND_SEARCH: begin
        len = search_len();
        if (len != 0) begin
          hops_left = len;
          walk_x = cfg_gx;
          walk_y = cfg_gy;
          walk_on = 1;
          r.status = ST_FOUND;
          r.path_length = len;
        end else begin
          hops_left = 0;
          walk_on = 0;
          r.status = ST_NOPATH;
        end
      end
      KIND_READ: begin
        if (walk_on && hops_left != 0) begin
          r.status = ST_CELL;
          r.out_x = walk_x;
          r.out_y = walk_y;
          r.last = (hops_left == 1);
          hops_left = hops_left - 11'd1;
          if (hops_left == 0) walk_on = 0;
          else {walk_y, walk_x} = hop(par_m[{walk_y, walk_x}], {walk_y, walk_x});
        end else begin
          walk_on = 0;
          r.status = ST_END;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // Monitor: results first, since a result always belongs to an older beat.
  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (route_q.size() == 0) report("unexpected result, status", got.status, -1);
        else begin
          want = route_q.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.path_length != want.path_length)
            report("path_length", got.path_length, want.path_length);
          if (got.out_x != want.out_x) report("out_x", got.out_x, want.out_x);
          if (got.out_y != want.out_y) report("out_y", got.out_y, want.out_y);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
      if (in_ch.valid && in_ch.ready) route_q.push_back(predict_result(in_ch.payload));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
    feed_taken <= in_ch.valid && in_ch.ready;
  end

  // Driver: a new beat goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || feed_taken) begin
      if (feed_gap != 0) begin
        feed_gap <= feed_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        in_ch.payload <= feed_q.pop_front();
        in_ch.valid <= 1'b1;
        feed_gap <= gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= ($urandom_range(0, 99) < 20) ? gap_len() : 0;
    end
  end

  task automatic push(input logic [1:0] kind, input int x, input int y, input bit w);
    in_item_t it;
    it.kind = kind;
    it.cell_x = x[4:0];
    it.cell_y = y[4:0];
    it.wall = w;
    feed_q.push_back(it);
    if (kind != KIND_SPARE) items_made++;
  endtask

  // Waits until every beat is taken and every result is in, then lets a read finish its step.
  task automatic drain();
    while (feed_q.size() != 0 || in_ch.valid || route_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_GRID_SIZE: cfg_size = val[5:0];
      REG_START_X:   cfg_sx = val[4:0];
      REG_START_Y:   cfg_sy = val[4:0];
      REG_GOAL_X:    cfg_gx = val[4:0];
      default:       cfg_gy = val[4:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic setup(input int sz, input int sx, input int sy, input int gx, input int gy);
    drain();
    write_reg(REG_GRID_SIZE, sz);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
  endtask

  initial begin
    int unsigned sz, span, n, reads;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    feed_taken = 0;
    feed_gap = 0;
    stall_left = 0;
    idle_cycles = 0;
    errors = 0;
    items_made = 0;
    calm = 0;
    cfg_size = 6'd29;
    cfg_sx = 5'd1;
    cfg_sy = 5'd1;
    cfg_gx = 5'd27;
    cfg_gy = 5'd27;
    foreach (wall_m[k]) wall_m[k] = 0;
    stamp_ctr = 0;
    walk_x = 0;
    walk_y = 0;
    walk_on = 0;
    hops_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Small grid: read with nothing pending, the spare kind, load extremes, a full walk.
    setup(3, 1, 1, 2, 2);
    push(KIND_READ, 0, 0, 0);
    push(KIND_SPARE, 31, 31, 1);
    push(KIND_LOAD, 31, 31, 1);
    push(KIND_LOAD, 0, 0, 0);
    push(KIND_LOAD, 31, 31, 0);
    push(KIND_SEARCH, 0, 0, 0);
    repeat (4) push(KIND_READ, 0, 0, 0);
    // Start equals goal.
    setup(3, 2, 2, 2, 2);
    push(KIND_SEARCH, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);
    // Goal on a wall, then start on a wall.
    setup(3, 1, 1, 2, 1);
    push(KIND_LOAD, 2, 1, 1);
    push(KIND_SEARCH, 0, 0, 0);
    push(KIND_LOAD, 2, 1, 0);
    push(KIND_LOAD, 1, 1, 1);
    push(KIND_SEARCH, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);
    push(KIND_LOAD, 1, 1, 0);
    // Largest grid size saturates; the far corner of the store.
    setup(63, 30, 30, 31, 31);
    push(KIND_LOAD, 30, 31, 0);
    push(KIND_LOAD, 31, 30, 0);
    push(KIND_SEARCH, 0, 0, 0);
    repeat (3) push(KIND_READ, 0, 0, 0);
    // A zero grid size leaves no neighbours at all.
    setup(0, 1, 1, 2, 1);
    push(KIND_SEARCH, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);
    setup(32, 31, 1, 31, 2);
    push(KIND_SEARCH, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);

    // Random phases on small grids, each a few loads, then one or two searches, each with a walk.
    while (items_made < ITEM_GOAL) begin
      sz = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 5) : $urandom_range(6, 7);
      span = ($urandom_range(0, 9) == 0) ? sz + 2 : sz - 1;
      setup(sz, $urandom_range(0, span), $urandom_range(0, span),
            $urandom_range(0, span), $urandom_range(0, span));
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 8);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          push(KIND_LOAD, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
        else
          push(KIND_LOAD, $urandom_range(0, sz), $urandom_range(0, sz),
               $urandom_range(0, 9) < 3);
      end
      repeat ($urandom_range(1, 2)) begin
        push(KIND_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
        reads = $urandom_range(0, 9) < 7 ? $urandom_range(2 * sz, 3 * sz) : $urandom_range(0, 3);
        repeat (reads) begin
          case ($urandom_range(0, 19))
            0: push(KIND_SPARE, $urandom_range(0, 31), $urandom_range(0, 31), 1);
            1: push(KIND_LOAD, $urandom_range(0, sz), $urandom_range(0, sz), 0);
            default: push(KIND_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 1));
          endcase
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
